### src/pcfs_pkg.sv
// ----------------------------------------------------------------------------
// pcfs_pkg
// Shared widths, codes and status types for the point charge field sum block.
// ----------------------------------------------------------------------------
package pcfs_pkg;

  localparam int POS_W       = 16;
  localparam int FIELD_W     = 32;
  localparam int K_W         = 32;
  localparam int ENTRY_W     = 3 * POS_W;
  localparam int DEFAULT_MAX_CHARGES = 64;
  localparam logic [K_W-1:0] K_RESET = 32'h0001_0000;

  localparam int S_W     = 33;
  localparam int ROOT_W  = 31;
  localparam int SQRT_W  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int DEN_W   = 64;
  localparam int KQ_W    = 48;
  localparam int NUM_W   = 64;
  localparam int MAG_W   = 40;
  localparam int SAT_SHIFT  = 26;
  localparam int FRAC_SHIFT = 14;
  localparam int ROOT_SHIFT = 28;
  localparam int ACC_W   = 64;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [MAG_W-1:0] mag;
  } div_stat_t;

endpackage

### src/point_charge_field_sum.sv
// ----------------------------------------------------------------------------
// point_charge_field_sum
// Table of 2D point charges with a superposed electric field query.
// ----------------------------------------------------------------------------
// An add request appends one charge, or is refused with accepted low when the
// table is full. A query request walks the stored charges one at a time
// through a single table read port, an iterative square root and two
// bit-serial dividers that run in step; a charge on the query point skips the
// square root and the dividers. One request is in work at a time; a finished
// result waits in the output register while the next request is taken. The
// table needs no clearing.
// ----------------------------------------------------------------------------
module point_charge_field_sum
  import pcfs_pkg::*;
#(
  parameter int MAX_CHARGES = DEFAULT_MAX_CHARGES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic signed [POS_W-1:0]   pos_x,
  input  logic signed [POS_W-1:0]   pos_y,
  input  logic signed [POS_W-1:0]   strength,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FIELD_W-1:0] field_x,
  output logic signed [FIELD_W-1:0] field_y,
  output logic                      accepted,
  output logic                      saturated,
  output logic                      coincident,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [K_W-1:0]            cfg_data
);

  localparam int ADDR_W = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
  localparam int CNT_W  = $clog2(MAX_CHARGES + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RD     = 4'd1;
  localparam logic [3:0] ST_DIFF   = 4'd2;
  localparam logic [3:0] ST_SQ     = 4'd3;
  localparam logic [3:0] ST_CHK    = 4'd4;
  localparam logic [3:0] ST_SQRT   = 4'd5;
  localparam logic [3:0] ST_MUL    = 4'd6;
  localparam logic [3:0] ST_MUL2   = 4'd7;
  localparam logic [3:0] ST_DSTART = 4'd8;
  localparam logic [3:0] ST_DIV    = 4'd9;
  localparam logic [3:0] ST_NEXT   = 4'd10;
  localparam logic [3:0] ST_FIN    = 4'd11;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(64'sh8000_0000);

  logic [3:0]              state;
  logic [CNT_W-1:0]        count;
  logic [ADDR_W-1:0]       idx;
  logic [K_W-1:0]          k;
  logic signed [POS_W-1:0] qx;
  logic signed [POS_W-1:0] qy;
  logic [POS_W-1:0]        adx;
  logic [POS_W-1:0]        ady;
  logic [POS_W-1:0]        aq;
  logic                    xneg;
  logic                    yneg;
  logic                    qneg;
  logic [S_W-1:0]          s;
  logic [ROOT_W-1:0]       r14;
  logic [DEN_W-1:0]        den;
  logic [KQ_W-1:0]         kq;
  logic [NUM_W-1:0]        numx;
  logic [NUM_W-1:0]        numy;
  logic signed [ACC_W-1:0] accx;
  logic signed [ACC_W-1:0] accy;
  logic                    sat;
  logic                    coin;
  logic                    res_query;
  logic                    add_ok;

  logic                    table_we;
  logic [ENTRY_W-1:0]      rdata;
  logic signed [POS_W:0]   dx;
  logic signed [POS_W:0]   dy;
  logic signed [POS_W:0]   eq;
  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [ROOT_W-1:0]       root;
  logic                    div_start;
  div_stat_t               dstat_x;
  div_stat_t               dstat_y;
  logic signed [ACC_W-1:0] cx;
  logic signed [ACC_W-1:0] cy;
  logic                    out_free;
  logic                    clx_hi, clx_lo, cly_hi, cly_lo;

  assign in_ready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign table_we   = in_valid && in_ready && op == OP_ADD && count < CNT_W'(MAX_CHARGES);
  assign sqrt_start = (state == ST_CHK) && s != '0;
  assign div_start  = (state == ST_DSTART);
  assign out_free   = !out_valid || out_ready;

  pcfs_table #(.DEPTH(MAX_CHARGES), .ADDR_W(ADDR_W)) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({pos_x, pos_y, strength}),
    .raddr (idx),
    .rdata (rdata)
  );

  pcfs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value ({{(SQRT_W - S_W - ROOT_SHIFT){1'b0}}, s, {ROOT_SHIFT{1'b0}}}),
    .done  (sqrt_done),
    .root  (root)
  );

  pcfs_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (numx),
    .den   (den),
    .stat  (dstat_x)
  );

  pcfs_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (numy),
    .den   (den),
    .stat  (dstat_y)
  );

  assign dx = $signed({qx[POS_W-1], qx})
            - $signed({rdata[ENTRY_W-1], rdata[ENTRY_W-1 -: POS_W]});
  assign dy = $signed({qy[POS_W-1], qy})
            - $signed({rdata[2*POS_W-1], rdata[2*POS_W-1 -: POS_W]});
  assign eq = $signed({rdata[POS_W-1], rdata[POS_W-1:0]});

  assign cx = (xneg != qneg) ? -$signed(ACC_W'(dstat_x.mag)) : $signed(ACC_W'(dstat_x.mag));
  assign cy = (yneg != qneg) ? -$signed(ACC_W'(dstat_y.mag)) : $signed(ACC_W'(dstat_y.mag));

  assign clx_hi = accx > ACC_MAX;
  assign clx_lo = accx < ACC_MIN;
  assign cly_hi = accy > ACC_MAX;
  assign cly_lo = accy < ACC_MIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      k         <= K_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        k <= cfg_data;
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (table_we) begin
        count <= count + CNT_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (op == OP_ADD || count == '0) begin
              state <= ST_FIN;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_RD:     state <= ST_DIFF;
        ST_DIFF:   state <= ST_SQ;
        ST_SQ:     state <= ST_CHK;
        ST_CHK:    state <= (s == '0) ? ST_NEXT : ST_SQRT;
        ST_SQRT: begin
          if (sqrt_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:    state <= ST_MUL2;
        ST_MUL2:   state <= ST_DSTART;
        ST_DSTART: state <= ST_DIV;
        ST_DIV: begin
          if (dstat_x.done) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          state <= (CNT_W'(idx) + CNT_W'(1) < count) ? ST_RD : ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          res_query <= (op == OP_QUERY);
          add_ok    <= count < CNT_W'(MAX_CHARGES);
          qx        <= pos_x;
          qy        <= pos_y;
          idx       <= '0;
          accx      <= '0;
          accy      <= '0;
          sat       <= 1'b0;
          coin      <= 1'b0;
        end
      end
      ST_DIFF: begin
        xneg <= dx[POS_W];
        yneg <= dy[POS_W];
        qneg <= eq[POS_W];
        adx  <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
        ady  <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
        aq   <= eq[POS_W] ? POS_W'(-eq) : eq[POS_W-1:0];
      end
      ST_SQ: begin
        s <= S_W'(32'(adx) * 32'(adx)) + S_W'(32'(ady) * 32'(ady));
      end
      ST_CHK: begin
        if (s == '0) begin
          coin <= 1'b1;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          r14 <= root;
        end
      end
      ST_MUL: begin
        den <= DEN_W'(s) * DEN_W'(r14);
        kq  <= KQ_W'(k) * KQ_W'(aq);
      end
      ST_MUL2: begin
        numx <= NUM_W'(kq) * NUM_W'(adx);
        numy <= NUM_W'(kq) * NUM_W'(ady);
      end
      ST_DIV: begin
        if (dstat_x.done) begin
          accx <= accx + cx;
          accy <= accy + cy;
          sat  <= sat | dstat_x.sat | dstat_y.sat;
        end
      end
      ST_NEXT: begin
        idx <= idx + ADDR_W'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          if (res_query) begin
            field_x    <= clx_hi ? FIELD_W'(ACC_MAX) : clx_lo ? FIELD_W'(ACC_MIN)
                                                       : accx[FIELD_W-1:0];
            field_y    <= cly_hi ? FIELD_W'(ACC_MAX) : cly_lo ? FIELD_W'(ACC_MIN)
                                                       : accy[FIELD_W-1:0];
            accepted   <= 1'b1;
            saturated  <= sat | clx_hi | clx_lo | cly_hi | cly_lo;
            coincident <= coin;
          end else begin
            field_x    <= '0;
            field_y    <= '0;
            accepted   <= add_ok;
            saturated  <= 1'b0;
            coincident <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CHARGES))
    else $error("charge count beyond table depth");

  a_full_add_keeps: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_ADD && count == CNT_W'(MAX_CHARGES) |=> $stable(count))
    else $error("add into full table changed count");

  a_add_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_free && !res_query
      |=> field_x == '0 && field_y == '0 && !saturated && !coincident)
    else $error("add result carries field data");

  a_div_lanes: assert property (@(posedge clk) disable iff (rst)
    dstat_x.done == dstat_y.done)
    else $error("divider lanes out of step");

endmodule

### src/pcfs_table.sv
// ----------------------------------------------------------------------------
// pcfs_table
// Charge table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcfs_table
  import pcfs_pkg::*;
#(
  parameter int DEPTH  = DEFAULT_MAX_CHARGES,
  parameter int ADDR_W = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/pcfs_sqrt.sv
// ----------------------------------------------------------------------------
// pcfs_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pcfs_sqrt
  import pcfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQRT_W-1:0] value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic              busy;
  logic [SQRT_W-1:0] rem;
  logic [SQRT_W-1:0] res;
  logic [SQRT_W-1:0] bitv;
  logic [4:0]        cnt;
  logic [SQRT_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitv <= SQRT_W'(1) << (SQRT_W - 2);
      cnt  <= 5'(SQRT_STEPS - 1);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt - 5'd1;
    end
  end

endmodule

### src/pcfs_div.sv
// ----------------------------------------------------------------------------
// pcfs_div
// Bit-serial restoring divider for one field component, with clamp detect.
// ----------------------------------------------------------------------------
module pcfs_div
  import pcfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_stat_t        stat
);

  logic                     busy;
  logic                     done;
  logic                     sat;
  logic [DEN_W-1:0]         rem;
  logic [MAG_W-1:0]         lo;
  logic [MAG_W-1:0]         quo;
  logic [5:0]               cnt;
  logic [DEN_W:0]           rem2;
  logic                     big;

  assign big  = {{SAT_SHIFT{1'b0}}, num} >= {den, {SAT_SHIFT{1'b0}}};
  assign rem2 = {rem, lo[MAG_W-1]};

  assign stat.done = done;
  assign stat.sat  = sat;
  assign stat.mag  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat <= big;
      rem <= DEN_W'(num[NUM_W-1:SAT_SHIFT]);
      lo  <= {num[SAT_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
      quo <= big ? '1 : '0;
      cnt <= 6'(MAG_W - 1);
    end else if (busy) begin
      if (!sat) begin
        if (rem2 >= {1'b0, den}) begin
          rem <= DEN_W'(rem2 - {1'b0, den});
          quo <= {quo[MAG_W-2:0], 1'b1};
        end else begin
          rem <= rem2[DEN_W-1:0];
          quo <= {quo[MAG_W-2:0], 1'b0};
        end
        lo <= lo << 1;
      end
      cnt <= cnt - 6'd1;
    end
  end

endmodule

### test/tb_point_charge_field_sum.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_charge_field_sum
// Self-checking bench for the point charge field sum block.
// ----------------------------------------------------------------------------
// Charges are added and the field is queried over valid/ready channels, with
// both sides stalling at random in the first two random phases. A scoreboard keeps its own charge table and
// fixed-point field math, and checks every result in order against it. The
// field constant is rewritten between phases, including zero and full scale.
// ----------------------------------------------------------------------------
import pcfs_pkg::*;

typedef struct {
  logic signed [FIELD_W-1:0] fx;
  logic signed [FIELD_W-1:0] fy;
  logic                      acc;
  logic                      sat;
  logic                      coin;
} field_result_t;

class field_scoreboard;
  logic [K_W-1:0]          k_const;
  logic signed [POS_W-1:0] tab_x[DEFAULT_MAX_CHARGES];
  logic signed [POS_W-1:0] tab_y[DEFAULT_MAX_CHARGES];
  logic signed [POS_W-1:0] tab_q[DEFAULT_MAX_CHARGES];
  int                      n_charges;
  field_result_t           expected_q[$];
  int                      errors;

  function new();
    k_const   = K_RESET;
    n_charges = 0;
    errors    = 0;
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function longint component(logic [63:0] kq, logic qneg, int dc, logic [63:0] den,
                             inout logic sat);
    logic [63:0]  num;
    logic [127:0] quo;
    logic [63:0]  mag;
    if (dc == 0 || kq == 0) return 0;
    num = kq * 64'(dc < 0 ? -dc : dc);
    quo = ({64'd0, num} << FRAC_SHIFT) / {64'd0, den};
    mag = quo[63:0];
    if (mag > 64'hFF_FFFF_FFFF) begin
      mag = 64'hFF_FFFF_FFFF;
      sat = 1'b1;
    end
    return ((dc < 0) != qneg) ? -longint'(mag) : longint'(mag);
  endfunction

  function logic signed [31:0] clamp(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function void note_request(logic op, logic signed [POS_W-1:0] px,
                             logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] q);
    field_result_t r;
    longint sx, sy;
    int dx, dy;
    logic [63:0] s, r14, den, kq;
    r = '{0, 0, 0, 0, 0};
    sx = 0;
    sy = 0;
    if (op == OP_ADD) begin
      if (n_charges < DEFAULT_MAX_CHARGES) begin
        tab_x[n_charges] = px;
        tab_y[n_charges] = py;
        tab_q[n_charges] = q;
        n_charges++;
        r.acc = 1'b1;
      end
    end else begin
      for (int i = 0; i < n_charges; i++) begin
        dx = int'(px) - int'(tab_x[i]);
        dy = int'(py) - int'(tab_y[i]);
        s  = 64'(longint'(dx) * dx) + 64'(longint'(dy) * dy);
        if (s == 0) begin
          r.coin = 1'b1;
          continue;
        end
        r14 = int_sqrt(s << ROOT_SHIFT);
        den = s * r14;
        kq  = 64'(k_const) * 64'(tab_q[i] < 0 ? -int'(tab_q[i]) : int'(tab_q[i]));
        sx += component(kq, tab_q[i] < 0, dx, den, r.sat);
        sy += component(kq, tab_q[i] < 0, dy, den, r.sat);
      end
      r.fx  = clamp(sx, r.sat);
      r.fy  = clamp(sy, r.sat);
      r.acc = 1'b1;
    end
    expected_q = {expected_q, r};
  endfunction

  function void check_result(field_result_t got);
    field_result_t exp;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result fx=%0d fy=%0d", got.fx, got.fy);
      return;
    end
    exp = expected_q.pop_front();
    if (got.fx !== exp.fx || got.fy !== exp.fy || got.acc !== exp.acc ||
        got.sat !== exp.sat || got.coin !== exp.coin) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: exp fx=%0d fy=%0d acc=%b sat=%b coin=%b,",
                 exp.fx, exp.fy, exp.acc, exp.sat, exp.coin,
                 " got fx=%0d fy=%0d acc=%b sat=%b coin=%b",
                 got.fx, got.fy, got.acc, got.sat, got.coin);
    end
  endfunction
endclass

module tb_point_charge_field_sum;
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      op = OP_ADD;
  logic signed [POS_W-1:0]   pos_x = '0;
  logic signed [POS_W-1:0]   pos_y = '0;
  logic signed [POS_W-1:0]   strength = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;
  logic                      accepted;
  logic                      saturated;
  logic                      coincident;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [K_W-1:0]            cfg_data = '0;

  field_scoreboard         sb = new();
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;
  logic signed [POS_W-1:0] placed_x[$];
  logic signed [POS_W-1:0] placed_y[$];

  point_charge_field_sum dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .pos_x(pos_x), .pos_y(pos_y), .strength(strength),
    .out_valid(out_valid), .out_ready(out_ready),
    .field_x(field_x), .field_y(field_y),
    .accepted(accepted), .saturated(saturated), .coincident(coincident),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{field_x, field_y, accepted, saturated, coincident});
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(logic o, logic signed [POS_W-1:0] x,
                              logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    pos_x    <= x;
    pos_y    <= y;
    strength <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(o, x, y, q);
    if (o == OP_ADD) begin
      placed_x = {placed_x, x};
      placed_y = {placed_y, y};
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_k(logic [K_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.k_const = v;
    @(posedge clk);
  endtask

  task automatic random_phase(int n_items);
    logic signed [POS_W-1:0] x, y;
    int j;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 8) begin
        if (placed_x.size() != 0 && $urandom_range(3) == 0) begin
          j = $urandom_range(placed_x.size() - 1);
          x = placed_x[j];
          y = placed_y[j];
        end else if ($urandom_range(1)) begin
          x = 16'($urandom);
          y = 16'($urandom);
        end else begin
          x = $signed(16'($urandom_range(40))) - 16'sd20;
          y = $signed(16'($urandom_range(40))) - 16'sd20;
        end
        send_request(OP_QUERY, x, y, 16'($urandom));
      end else begin
        if ($urandom_range(1)) begin
          x = 16'($urandom);
          y = 16'($urandom);
        end else begin
          x = $signed(16'($urandom_range(40))) - 16'sd20;
          y = $signed(16'($urandom_range(40))) - 16'sd20;
        end
        send_request(OP_ADD, x, y, 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_k(32'hFFFF_FFFF);
    send_request(OP_QUERY, 16'sd0, 16'sd0, 16'sd0);
    send_request(OP_ADD, 16'sd0, 16'sd0, 16'sh7FFF);
    send_request(OP_ADD, 16'sd1, 16'sd0, 16'sh8000);
    send_request(OP_ADD, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_request(OP_ADD, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_request(OP_ADD, 16'sd0, 16'sd1, 16'sd0);
    send_request(OP_QUERY, 16'sd0, 16'sd0, 16'sd0);
    send_request(OP_QUERY, 16'sd1, 16'sd1, 16'sh7FFF);
    send_request(OP_QUERY, 16'sh7FFF, 16'sh8000, 16'sd0);
    send_request(OP_QUERY, 16'sh8000, 16'sh7FFF, 16'sh8000);
    drain();
    write_k(32'd0);
    send_request(OP_QUERY, 16'sd5, 16'sd5, 16'sd0);
    drain();
    write_k(K_RESET);
    send_request(OP_QUERY, 16'sd2, 16'sd0, 16'sd0);
    send_request(OP_QUERY, -16'sd1, -16'sd1, 16'sd0);
    send_request(OP_QUERY, 16'sd300, -16'sd200, 16'sd0);
    drain();

    send_idle_pct = 11;
    recv_idle_pct = 51;
    write_k($urandom_range(32'h0010_0000));
    random_phase(400);
    drain();
    send_idle_pct = 51;
    recv_idle_pct = 11;
    write_k($urandom);
    random_phase(400);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_k(K_RESET);
    random_phase(400);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
